// ===== sv/tga_dec_pkg.sv =====
// Shared types and constants for the TGA run-length stream decoder.
package tga_dec_pkg;

    // Largest accepted image side in pixels
    localparam logic [14:0] MAX_SIDE = 15'd32767;

    // Signature block
    localparam logic [3:0] SIG_LEN       = 4'd12;
    localparam logic [3:0] SIG_CHECKED   = 4'd6;
    localparam logic [3:0] SIG_TYPE_POS  = 4'd2;
    localparam logic [7:0] SIG_TYPE_RAW  = 8'd2;
    localparam logic [7:0] SIG_TYPE_RLE  = 8'd10;

    // Image field positions after the signature
    localparam logic [3:0] FLD_WIDTH_LO  = 4'd0;
    localparam logic [3:0] FLD_WIDTH_HI  = 4'd1;
    localparam logic [3:0] FLD_HEIGHT_LO = 4'd2;
    localparam logic [3:0] FLD_HEIGHT_HI = 4'd3;
    localparam logic [3:0] FLD_DEPTH     = 4'd4;

    localparam logic [7:0] DEPTH_24      = 8'd24;
    localparam logic [7:0] DEPTH_32      = 8'd32;
    localparam int         DESC_TOP_BIT  = 5;

    // Packet header: top bit marks a repeated pixel
    localparam logic [7:0] PKT_RUN_FLAG  = 8'd128;
    localparam logic [7:0] PKT_RUN_BIAS  = 8'd127;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SIG    = 3'd1,
        PH_FIELDS = 3'd2,
        PH_HEAD   = 3'd3,
        PH_COLOR  = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_RUN      = 3'd1,
        KIND_BAD_SIG  = 3'd2,
        KIND_BAD_SIZE = 3'd3,
        KIND_TRUNC    = 3'd4,
        KIND_TOO_MANY = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_length;
        logic [29:0] first_index;
        logic        image_done;
        logic [14:0] image_width;
        logic [14:0] image_height;
        logic        has_alpha;
        logic        top_down;
    } t_result;

endpackage

// ===== sv/tga_dec_parser.sv =====
// Byte parser: header checks, packet decode and pixel gathering, one byte per cycle while accepted.
module tga_dec_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_file,
    input  logic                 i_end_of_input,
    output logic                 o_emit,
    output tga_dec_pkg::t_result o_result
);

    tga_dec_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_compressed, n_compressed;
    logic [14:0] r_width, n_width;
    logic [14:0] r_height, n_height;
    logic        r_four, n_four;
    logic        r_top_down, n_top_down;
    logic [29:0] r_total, n_total;
    logic [29:0] r_done, n_done;
    logic        r_is_run, n_is_run;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_color, n_color;
    logic [1:0]  r_bip, n_bip;

    // Next state and result for the byte being accepted
    always_comb begin
        logic [15:0] side;
        logic [7:0]  len;
        logic [29:0] remain;
        logic [2:0]  bip_inc;
        logic [2:0]  nbytes;

        side    = '0;
        len     = '0;
        remain  = '0;
        bip_inc = '0;
        nbytes  = '0;

        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_compressed = r_compressed;
        n_width      = r_width;
        n_height     = r_height;
        n_four       = r_four;
        n_top_down   = r_top_down;
        n_total      = r_total;
        n_done       = r_done;
        n_is_run     = r_is_run;
        n_left       = r_left;
        n_color      = r_color;
        n_bip        = r_bip;
        o_emit       = 1'b0;
        o_result     = '0;

        if (i_accept) begin
            // Start of file clears the parser first
            if (i_start_of_file) begin
                n_phase      = tga_dec_pkg::PH_SIG;
                n_hdr_cnt    = '0;
                n_compressed = 1'b0;
                n_width      = '0;
                n_height     = '0;
                n_four       = 1'b0;
                n_top_down   = 1'b0;
                n_total      = '0;
                n_done       = '0;
                n_is_run     = 1'b0;
                n_left       = '0;
                n_color      = '0;
                n_bip        = '0;
            end

            if (i_end_of_input) begin
                if (n_phase == tga_dec_pkg::PH_SIG || n_phase == tga_dec_pkg::PH_FIELDS ||
                    n_phase == tga_dec_pkg::PH_HEAD || n_phase == tga_dec_pkg::PH_COLOR) begin
                    n_phase       = tga_dec_pkg::PH_DONE;
                    o_emit        = 1'b1;
                    o_result.kind = tga_dec_pkg::KIND_TRUNC;
                end
            end else begin
                case (n_phase)
                    // Signature block: type byte plus zero bytes, then unchecked bytes
                    tga_dec_pkg::PH_SIG: begin
                        if (n_hdr_cnt == tga_dec_pkg::SIG_TYPE_POS &&
                            i_data_byte != tga_dec_pkg::SIG_TYPE_RAW &&
                            i_data_byte != tga_dec_pkg::SIG_TYPE_RLE) begin
                            n_phase       = tga_dec_pkg::PH_DONE;
                            o_emit        = 1'b1;
                            o_result.kind = tga_dec_pkg::KIND_BAD_SIG;
                        end else if (n_hdr_cnt != tga_dec_pkg::SIG_TYPE_POS &&
                                     n_hdr_cnt < tga_dec_pkg::SIG_CHECKED &&
                                     i_data_byte != 8'd0) begin
                            n_phase       = tga_dec_pkg::PH_DONE;
                            o_emit        = 1'b1;
                            o_result.kind = tga_dec_pkg::KIND_BAD_SIG;
                        end else begin
                            if (n_hdr_cnt == tga_dec_pkg::SIG_TYPE_POS) begin
                                n_compressed = (i_data_byte == tga_dec_pkg::SIG_TYPE_RLE);
                            end
                            n_hdr_cnt = n_hdr_cnt + 4'd1;
                            if (n_hdr_cnt >= tga_dec_pkg::SIG_LEN) begin
                                n_hdr_cnt = '0;
                                n_phase   = tga_dec_pkg::PH_FIELDS;
                            end
                        end
                    end

                    // Size, depth and descriptor
                    tga_dec_pkg::PH_FIELDS: begin
                        case (n_hdr_cnt)
                            tga_dec_pkg::FLD_WIDTH_LO: begin
                                n_width   = {7'd0, i_data_byte};
                                n_hdr_cnt = n_hdr_cnt + 4'd1;
                            end
                            tga_dec_pkg::FLD_WIDTH_HI: begin
                                side = {i_data_byte, n_width[7:0]};
                                if (side[15] || side == 16'd0 ||
                                    side[14:0] > tga_dec_pkg::MAX_SIDE) begin
                                    n_phase       = tga_dec_pkg::PH_DONE;
                                    o_emit        = 1'b1;
                                    o_result.kind = tga_dec_pkg::KIND_BAD_SIZE;
                                end else begin
                                    n_width   = side[14:0];
                                    n_hdr_cnt = n_hdr_cnt + 4'd1;
                                end
                            end
                            tga_dec_pkg::FLD_HEIGHT_LO: begin
                                n_height  = {7'd0, i_data_byte};
                                n_hdr_cnt = n_hdr_cnt + 4'd1;
                            end
                            tga_dec_pkg::FLD_HEIGHT_HI: begin
                                side = {i_data_byte, n_height[7:0]};
                                if (side[15] || side == 16'd0 ||
                                    side[14:0] > tga_dec_pkg::MAX_SIDE) begin
                                    n_phase       = tga_dec_pkg::PH_DONE;
                                    o_emit        = 1'b1;
                                    o_result.kind = tga_dec_pkg::KIND_BAD_SIZE;
                                end else begin
                                    n_height  = side[14:0];
                                    n_hdr_cnt = n_hdr_cnt + 4'd1;
                                end
                            end
                            tga_dec_pkg::FLD_DEPTH: begin
                                if (i_data_byte != tga_dec_pkg::DEPTH_24 &&
                                    i_data_byte != tga_dec_pkg::DEPTH_32) begin
                                    n_phase       = tga_dec_pkg::PH_DONE;
                                    o_emit        = 1'b1;
                                    o_result.kind = tga_dec_pkg::KIND_BAD_SIZE;
                                end else begin
                                    n_four    = (i_data_byte == tga_dec_pkg::DEPTH_32);
                                    n_hdr_cnt = n_hdr_cnt + 4'd1;
                                end
                            end
                            default: begin
                                // Descriptor byte closes the header
                                n_top_down = i_data_byte[tga_dec_pkg::DESC_TOP_BIT];
                                n_total    = {15'd0, n_width} * {15'd0, n_height};
                                n_done     = '0;
                                n_bip      = '0;
                                n_color    = '0;
                                n_hdr_cnt  = '0;
                                n_phase    = n_compressed ? tga_dec_pkg::PH_HEAD
                                                          : tga_dec_pkg::PH_COLOR;
                                o_emit                = 1'b1;
                                o_result.kind         = tga_dec_pkg::KIND_HEADER;
                                o_result.image_width  = n_width;
                                o_result.image_height = n_height;
                                o_result.has_alpha    = n_four;
                                o_result.top_down     = n_top_down;
                            end
                        endcase
                    end

                    // Packet header: length check against pixels still missing
                    tga_dec_pkg::PH_HEAD: begin
                        if (i_data_byte < tga_dec_pkg::PKT_RUN_FLAG) begin
                            n_is_run = 1'b0;
                            len      = i_data_byte + 8'd1;
                        end else begin
                            n_is_run = 1'b1;
                            len      = i_data_byte - tga_dec_pkg::PKT_RUN_BIAS;
                        end
                        remain = n_total - n_done;
                        if ({22'd0, len} > remain) begin
                            n_phase       = tga_dec_pkg::PH_DONE;
                            o_emit        = 1'b1;
                            o_result.kind = tga_dec_pkg::KIND_TOO_MANY;
                        end else begin
                            n_left  = len;
                            n_bip   = '0;
                            n_color = '0;
                            n_phase = tga_dec_pkg::PH_COLOR;
                        end
                    end

                    // Pixel bytes B,G,R[,A]
                    tga_dec_pkg::PH_COLOR: begin
                        n_color[8*n_bip +: 8] = n_color[8*n_bip +: 8] | i_data_byte;
                        bip_inc = {1'b0, n_bip} + 3'd1;
                        nbytes  = n_four ? 3'd4 : 3'd3;
                        if (bip_inc < nbytes) begin
                            n_bip = bip_inc[1:0];
                        end else begin
                            n_bip = '0;
                            len   = (n_compressed && n_is_run) ? n_left : 8'd1;
                            o_emit               = 1'b1;
                            o_result.kind        = tga_dec_pkg::KIND_RUN;
                            o_result.red         = n_color[23:16];
                            o_result.green       = n_color[15:8];
                            o_result.blue        = n_color[7:0];
                            o_result.alpha       = n_four ? n_color[31:24] : 8'd0;
                            o_result.run_length  = len;
                            o_result.first_index = n_done;
                            n_done  = n_done + {22'd0, len};
                            n_color = '0;
                            if (n_compressed) begin
                                n_left = n_is_run ? 8'd0 : n_left - 8'd1;
                            end
                            if (n_done >= n_total) begin
                                o_result.image_done = 1'b1;
                                n_phase = tga_dec_pkg::PH_DONE;
                            end else if (n_compressed && n_left == 8'd0) begin
                                n_phase = tga_dec_pkg::PH_HEAD;
                            end
                        end
                    end

                    default: begin
                        // Idle or finished: wait for start of file
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tga_dec_pkg::PH_IDLE;
            r_hdr_cnt    <= '0;
            r_compressed <= 1'b0;
            r_width      <= '0;
            r_height     <= '0;
            r_four       <= 1'b0;
            r_top_down   <= 1'b0;
            r_total      <= '0;
            r_done       <= '0;
            r_is_run     <= 1'b0;
            r_left       <= '0;
            r_color      <= '0;
            r_bip        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_compressed <= n_compressed;
            r_width      <= n_width;
            r_height     <= n_height;
            r_four       <= n_four;
            r_top_down   <= n_top_down;
            r_total      <= n_total;
            r_done       <= n_done;
            r_is_run     <= n_is_run;
            r_left       <= n_left;
            r_color      <= n_color;
            r_bip        <= n_bip;
        end
    end

endmodule

// ===== sv/tga_dec_out_buf.sv =====
// Two-entry result register with skid slot, decoupling the parser from a stalled receiver.
module tga_dec_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  tga_dec_pkg::t_result i_data,
    output logic                 o_not_full,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tga_dec_pkg::t_result o_data
);

    logic                 r_main_valid;
    logic                 r_skid_valid;
    tga_dec_pkg::t_result r_main;
    tga_dec_pkg::t_result r_skid;
    logic                 pop;

    assign pop        = r_main_valid & i_ready;
    assign o_not_full = ~r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_wr;
            end
        end else if (i_wr) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_wr) begin
                r_main <= i_data;
            end
        end else if (i_wr) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

// ===== sv/tga_rle_stream_decoder.sv =====
// Top level of the TGA run-length stream decoder.
// Usage:
//   Input channel (i_valid/o_ready) carries one file byte per request, with
//   start_of_file on the first byte and end_of_input to mark the end of the
//   stream. Output channel (o_valid/i_ready) carries at most one result per
//   input request: header, pixel run, or an error kind.
//   A result is written into the result register when the byte that
//   causes it is accepted. Throughput: one byte per cycle while o_ready is
//   high, set by the combinational parser feeding the result register.
//   The 15x15 size multiply is done once, on the descriptor byte.
//   A receiver stall is absorbed by a skid slot: bytes are still taken while
//   a result waits; o_ready drops only when both result slots are full.
//   Reset (synchronous, active low) empties the result slots and puts the
//   parser in idle, where bytes are ignored until start_of_file.
//   After an error or a finished image the parser is idle again until the
//   next start_of_file.
module tga_rle_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_run_length,
    output logic [29:0] o_first_index,
    output logic        o_image_done,
    output logic [14:0] o_image_width,
    output logic [14:0] o_image_height,
    output logic        o_has_alpha,
    output logic        o_top_down
);

    logic                 accept;
    logic                 emit;
    logic                 not_full;
    tga_dec_pkg::t_result result;
    tga_dec_pkg::t_result out_data;

    assign o_ready = not_full;
    assign accept  = i_valid & not_full;

    tga_dec_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_end_of_input  (i_end_of_input),
        .o_emit          (emit),
        .o_result        (result)
    );

    tga_dec_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (emit),
        .i_data     (result),
        .o_not_full (not_full),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (out_data)
    );

    // Unpack result fields
    assign o_kind         = out_data.kind;
    assign o_red          = out_data.red;
    assign o_green        = out_data.green;
    assign o_blue         = out_data.blue;
    assign o_alpha        = out_data.alpha;
    assign o_run_length   = out_data.run_length;
    assign o_first_index  = out_data.first_index;
    assign o_image_done   = out_data.image_done;
    assign o_image_width  = out_data.image_width;
    assign o_image_height = out_data.image_height;
    assign o_has_alpha    = out_data.has_alpha;
    assign o_top_down     = out_data.top_down;

endmodule

// ===== bench/tga_rle_stream_decoder_tb.sv =====
// Self-checking bench for the TGA run-length stream decoder: directed bytes, then random files.
module tga_rle_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_dec_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_ITEMS    = 306;
    localparam int unsigned FLD_BASE       = 12;

    // Sender gap and receiver stall, in percent, per phase
    localparam int unsigned GAP_PCT   [4] = '{0, 73, 0, 21};
    localparam int unsigned STALL_PCT [4] = '{0, 0, 73, 21};

    // Ways a random file departs from a well-formed one
    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_SIG,
        FLAW_SIZE,
        FLAW_TRUNC,
        FLAW_TOO_MANY,
        FLAW_RESTART,
        FLAW_HUGE
    } t_flaw;

    // One input request; fixed rows carry their expected result typed in
    typedef struct packed {
        logic [7:0]  data;
        logic        sof;
        logic        eoi;
        logic        fixed;
        t_kind       want_kind;
        logic [14:0] want_width;
        logic [14:0] want_height;
        logic        want_alpha;
        logic        want_top;
    } t_req;

    localparam t_req DIRECTED_PLAN [24] = '{
        // bytes and end marks before any start are dropped
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        // start together with end
        '{8'h00, 1'b1, 1'b1, 1'b1, KIND_TRUNC,    15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        // first signature byte nonzero
        '{8'hFF, 1'b1, 1'b0, 1'b1, KIND_BAD_SIG,  15'd0, 15'd0, 1'b0, 1'b0},
        // RLE signature, skipped bytes all ones
        '{8'h00, 1'b1, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        // 1x1, 32 bits, descriptor all ones
        '{8'h01, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'd32, 1'b0, 1'b0, 1'b0, KIND_HEADER,   15'd0, 15'd0, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 1'b1, KIND_HEADER,   15'd1, 15'd1, 1'b1, 1'b1},
        // run packet of two with one pixel left
        '{8'h81, 1'b0, 1'b0, 1'b1, KIND_TOO_MANY, 15'd0, 15'd0, 1'b0, 1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_start_of_file = 1'b0;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [7:0]  o_run_length;
    logic [29:0] o_first_index;
    logic        o_image_done;
    logic [14:0] o_image_width;
    logic [14:0] o_image_height;
    logic        o_has_alpha;
    logic        o_top_down;

    t_result     pending_results[$];
    t_req        file_reqs[$];
    int unsigned sender_gap_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;

    // Decoder state as the bench tracks it
    t_phase      dec_phase;
    logic [3:0]  dec_hdr_cnt;
    logic        dec_rle;
    logic [14:0] dec_width;
    logic [14:0] dec_height;
    logic        dec_wide;
    logic        dec_top;
    logic [29:0] dec_total;
    logic [29:0] dec_done_px;
    logic        dec_pkt_run;
    logic [7:0]  dec_pkt_left;
    logic [31:0] dec_color;
    logic [2:0]  dec_byte_pos;

    tga_rle_stream_decoder DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_decoder();
        dec_phase    = PH_IDLE;
        dec_hdr_cnt  = '0;
        dec_rle      = 1'b0;
        dec_width    = '0;
        dec_height   = '0;
        dec_wide     = 1'b0;
        dec_top      = 1'b0;
        dec_total    = '0;
        dec_done_px  = '0;
        dec_pkt_run  = 1'b0;
        dec_pkt_left = '0;
        dec_color    = '0;
        dec_byte_pos = '0;
    endfunction

    // Error result; the parser waits for the next start
    function automatic bit abort(output t_result res, input t_kind k);
        dec_phase = PH_DONE;
        res       = '0;
        res.kind  = k;
        return 1'b1;
    endfunction

    // Steps the tracked decoder by one byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                       input logic eoi, output t_result res);
        logic [15:0] side;
        logic [7:0]  len;
        res = '0;
        if (sof) begin
            clear_decoder();
            dec_phase = PH_SIG;
        end
        if (eoi) begin
            if (dec_phase != PH_IDLE && dec_phase != PH_DONE)
                return abort(res, KIND_TRUNC);
            return 1'b0;
        end

        case (dec_phase)
            PH_SIG: begin
                if (dec_hdr_cnt == SIG_TYPE_POS) begin
                    if (b == SIG_TYPE_RAW)
                        dec_rle = 1'b0;
                    else if (b == SIG_TYPE_RLE)
                        dec_rle = 1'b1;
                    else
                        return abort(res, KIND_BAD_SIG);
                end else if (dec_hdr_cnt < SIG_CHECKED && b != 8'd0) begin
                    return abort(res, KIND_BAD_SIG);
                end
                dec_hdr_cnt++;
                if (dec_hdr_cnt >= SIG_LEN) begin
                    dec_hdr_cnt = '0;
                    dec_phase   = PH_FIELDS;
                end
                return 1'b0;
            end

            PH_FIELDS: begin
                case (dec_hdr_cnt)
                    FLD_WIDTH_LO: dec_width = {7'd0, b};
                    FLD_WIDTH_HI: begin
                        side = {b, dec_width[7:0]};
                        if (b[7] || side == 16'd0 || side > MAX_SIDE)
                            return abort(res, KIND_BAD_SIZE);
                        dec_width = side[14:0];
                    end
                    FLD_HEIGHT_LO: dec_height = {7'd0, b};
                    FLD_HEIGHT_HI: begin
                        side = {b, dec_height[7:0]};
                        if (b[7] || side == 16'd0 || side > MAX_SIDE)
                            return abort(res, KIND_BAD_SIZE);
                        dec_height = side[14:0];
                    end
                    FLD_DEPTH: begin
                        if (b != DEPTH_24 && b != DEPTH_32)
                            return abort(res, KIND_BAD_SIZE);
                        dec_wide = (b == DEPTH_32);
                    end
                    default: begin
                        // descriptor byte closes the header
                        dec_top      = b[DESC_TOP_BIT];
                        dec_total    = dec_width * dec_height;
                        dec_done_px  = '0;
                        dec_byte_pos = '0;
                        dec_color    = '0;
                        dec_hdr_cnt  = '0;
                        dec_phase    = dec_rle ? PH_HEAD : PH_COLOR;
                        res.kind         = KIND_HEADER;
                        res.image_width  = dec_width;
                        res.image_height = dec_height;
                        res.has_alpha    = dec_wide;
                        res.top_down     = dec_top;
                        return 1'b1;
                    end
                endcase
                dec_hdr_cnt++;
                return 1'b0;
            end

            PH_HEAD: begin
                dec_pkt_run = (b >= PKT_RUN_FLAG);
                len = dec_pkt_run ? b - PKT_RUN_BIAS : b + 8'd1;
                if (len > dec_total - dec_done_px)
                    return abort(res, KIND_TOO_MANY);
                dec_pkt_left = len;
                dec_byte_pos = '0;
                dec_color    = '0;
                dec_phase    = PH_COLOR;
                return 1'b0;
            end

            PH_COLOR: begin
                // bytes come in as B,G,R[,A]
                dec_color[8*dec_byte_pos[1:0] +: 8] = b;
                dec_byte_pos++;
                if (dec_byte_pos < (dec_wide ? 3'd4 : 3'd3))
                    return 1'b0;
                dec_byte_pos = '0;
                len = (dec_rle && dec_pkt_run) ? dec_pkt_left : 8'd1;
                res.kind        = KIND_RUN;
                res.red         = dec_color[23:16];
                res.green       = dec_color[15:8];
                res.blue        = dec_color[7:0];
                res.alpha       = dec_wide ? dec_color[31:24] : 8'd0;
                res.run_length  = len;
                res.first_index = dec_done_px;
                dec_done_px     = dec_done_px + len;
                dec_color       = '0;
                if (dec_rle)
                    dec_pkt_left = dec_pkt_run ? 8'd0 : dec_pkt_left - 8'd1;
                if (dec_done_px >= dec_total) begin
                    res.image_done = 1'b1;
                    dec_phase      = PH_DONE;
                end else if (dec_rle && dec_pkt_left == 8'd0) begin
                    dec_phase = PH_HEAD;
                end
                return 1'b1;
            end

            default: return 1'b0;
        endcase
    endfunction

    function automatic t_req plain_req(input logic [7:0] b, input logic sof, input logic eoi);
        t_req r;
        r      = '0;
        r.data = b;
        r.sof  = sof;
        r.eoi  = eoi;
        return r;
    endfunction

    // Offers one request, waits for it to be taken, then books its result
    task automatic send_request(input t_req rq);
        t_result got;
        t_result want;
        bit      made;
        while ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= rq.data;
        i_start_of_file <= rq.sof;
        i_end_of_input  <= rq.eoi;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        made = decode_byte(rq.data, rq.sof, rq.eoi, got);
        if (rq.fixed) begin
            want              = '0;
            want.kind         = rq.want_kind;
            want.image_width  = rq.want_width;
            want.image_height = rq.want_height;
            want.has_alpha    = rq.want_alpha;
            want.top_down     = rq.want_top;
            pending_results.push_back(want);
        end else if (made) begin
            pending_results.push_back(got);
        end
    endtask

    // Sender pause: drop valid and hold until every result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // Builds one random file, mostly well-formed, and sends it
    task automatic send_file(inout int unsigned count);
        t_flaw       flaw;
        int unsigned pick, w, h, left, len, packets, pos, keep;
        logic        rle, wide, run;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 62)      flaw = FLAW_NONE;
        else if (pick < 68) flaw = FLAW_SIG;
        else if (pick < 75) flaw = FLAW_SIZE;
        else if (pick < 83) flaw = FLAW_TRUNC;
        else if (pick < 90) flaw = FLAW_TOO_MANY;
        else if (pick < 95) flaw = FLAW_RESTART;
        else                flaw = FLAW_HUGE;
        rle  = (flaw == FLAW_TOO_MANY) ? 1'b1 : 1'($urandom_range(1));
        wide = $urandom_range(1);

        // mostly tiny images; medium ones only with RLE, for long runs; rare maximal side
        if (flaw == FLAW_HUGE) begin
            w = MAX_SIDE;
            h = $urandom_range(1, MAX_SIDE);
            if ($urandom_range(1)) begin
                left = w;
                w    = h;
                h    = left;
            end
        end else if (rle && $urandom_range(4) == 0) begin
            w = $urandom_range(8, 16);
            h = $urandom_range(8, 16);
        end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
        end

        file_reqs.delete();
        for (int k = 0; k < SIG_LEN; k++) begin
            if (k == SIG_TYPE_POS)
                b = rle ? SIG_TYPE_RLE : SIG_TYPE_RAW;
            else if (k < SIG_CHECKED)
                b = 8'd0;
            else
                b = $urandom_range(255);
            file_reqs.push_back(plain_req(b, k == 0, 1'b0));
        end
        file_reqs.push_back(plain_req(w[7:0], 1'b0, 1'b0));
        file_reqs.push_back(plain_req(w[15:8], 1'b0, 1'b0));
        file_reqs.push_back(plain_req(h[7:0], 1'b0, 1'b0));
        file_reqs.push_back(plain_req(h[15:8], 1'b0, 1'b0));
        file_reqs.push_back(plain_req(wide ? DEPTH_32 : DEPTH_24, 1'b0, 1'b0));
        file_reqs.push_back(plain_req($urandom_range(255), 1'b0, 1'b0));

        // pixel body; a huge image stops after six packets
        left    = w * h;
        packets = 0;
        while (left > 0 && !(flaw == FLAW_HUGE && packets == 6)) begin
            len = 1;
            run = 1'b0;
            if (rle) begin
                run = $urandom_range(1);
                if (flaw == FLAW_TOO_MANY && left < 128 &&
                    ($urandom_range(2) == 0 || left <= 4)) begin
                    len = $urandom_range(left + 1, 128);
                    file_reqs.push_back(plain_req(run ? len + 127 : len - 1, 1'b0, 1'b0));
                    break;
                end
                len = $urandom_range(1, left < 128 ? left : 128);
                file_reqs.push_back(plain_req(run ? len + 127 : len - 1, 1'b0, 1'b0));
            end
            for (int p = 0; p < (run ? 1 : len); p++)
                for (int q = 0; q < (wide ? 4 : 3); q++)
                    file_reqs.push_back(plain_req($urandom_range(255), 1'b0, 1'b0));
            left = left - len;
            packets++;
        end

        case (flaw)
            FLAW_SIG: begin
                pos = $urandom_range(0, SIG_CHECKED - 1);
                if (pos == SIG_TYPE_POS) begin
                    do
                        b = $urandom_range(255);
                    while (b == SIG_TYPE_RAW || b == SIG_TYPE_RLE);
                end else begin
                    b = $urandom_range(1, 255);
                end
                file_reqs[pos].data = b;
                keep = pos + 1;
            end
            FLAW_SIZE: begin
                case ($urandom_range(4))
                    0: begin
                        file_reqs[FLD_BASE + FLD_WIDTH_HI].data = 8'h80 | 8'($urandom_range(255));
                        keep = FLD_BASE + FLD_WIDTH_HI + 1;
                    end
                    1: begin
                        file_reqs[FLD_BASE + FLD_WIDTH_LO].data = 8'd0;
                        file_reqs[FLD_BASE + FLD_WIDTH_HI].data = 8'd0;
                        keep = FLD_BASE + FLD_WIDTH_HI + 1;
                    end
                    2: begin
                        file_reqs[FLD_BASE + FLD_HEIGHT_HI].data = 8'h80 | 8'($urandom_range(255));
                        keep = FLD_BASE + FLD_HEIGHT_HI + 1;
                    end
                    3: begin
                        file_reqs[FLD_BASE + FLD_HEIGHT_LO].data = 8'd0;
                        file_reqs[FLD_BASE + FLD_HEIGHT_HI].data = 8'd0;
                        keep = FLD_BASE + FLD_HEIGHT_HI + 1;
                    end
                    default: begin
                        do
                            b = $urandom_range(255);
                        while (b == DEPTH_24 || b == DEPTH_32);
                        file_reqs[FLD_BASE + FLD_DEPTH].data = b;
                        keep = FLD_BASE + FLD_DEPTH + 1;
                    end
                endcase
            end
            FLAW_TRUNC, FLAW_RESTART: keep = $urandom_range(1, file_reqs.size() - 1);
            default: keep = file_reqs.size();
        endcase
        while (file_reqs.size() > keep)
            void'(file_reqs.pop_back());

        // end mark mid-file; a restart just leaves the next file's start to cut in
        if (flaw == FLAW_TRUNC || (flaw == FLAW_HUGE && $urandom_range(1)))
            file_reqs.push_back(plain_req($urandom_range(255), 1'b0, 1'b1));

        foreach (file_reqs[k])
            send_request(file_reqs[k]);
        count += file_reqs.size();

        // stray bytes after the file, dropped if the parser is idle
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3))
                send_request(plain_req($urandom_range(255), 1'b0, 1'($urandom_range(1))));
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: compare each taken result, then pick next ready
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d", o_kind);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("alpha", want.alpha, o_alpha);
                check_field("run_length", want.run_length, o_run_length);
                check_field("first_index", want.first_index, o_first_index);
                check_field("image_done", want.image_done, o_image_done);
                check_field("image_width", want.image_width, o_image_width);
                check_field("image_height", want.image_height, o_image_height);
                check_field("has_alpha", want.has_alpha, o_has_alpha);
                check_field("top_down", want.top_down, o_top_down);
            end
        end
        // long hold-off counted here, otherwise random stalls
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles with no request taken on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL tga_rle_stream_decoder");
            $finish;
        end
    end

    initial begin
        int unsigned items;
        clear_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_PLAN[k])
            send_request(DIRECTED_PLAN[k]);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            sender_gap_pct     = GAP_PCT[p];
            receiver_stall_pct = STALL_PCT[p];
            // receiver holds off while the sender keeps pushing
            if (p == 0 || p == 2)
                hold_asks++;
            items = 0;
            while (items < PHASE_ITEMS)
                send_file(items);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS tga_rle_stream_decoder");
        else
            $display("FAIL tga_rle_stream_decoder");
        $finish;
    end

endmodule

// ===== tga_rle_stream_decoder.f =====
sv/tga_dec_pkg.sv
sv/tga_dec_parser.sv
sv/tga_dec_out_buf.sv
sv/tga_rle_stream_decoder.sv
bench/tga_rle_stream_decoder_tb.sv
